// ===== rtl/mrfc_pkg.sv =====
// Package for the Modbus RTU frame checker.
// Holds word types, status codes, sizes and the CRC-16 byte update.
// No dependencies.
`timescale 1ns / 1ps

package mrfc_pkg;

  localparam int MAX_FRAME_BYTES = 256;
  localparam int MIN_FRAME       = 3;
  localparam int CRC_BYTES       = 2;
  localparam int BITS_PER_BYTE   = 8;
  localparam int CNT_W           = 9;
  localparam int QUEUE_DEPTH     = 4;
  localparam int QPTR_W          = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W          = $clog2(QUEUE_DEPTH + 1);

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam logic       KIND_PDU     = 1'b0;
  localparam logic       KIND_VERDICT = 1'b1;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_SHORT    = 2'd1;
  localparam logic [1:0] STATUS_CRC_ERR  = 2'd2;
  localparam logic [1:0] STATUS_OVERLONG = 2'd3;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       end_of_frame;
  } in_t;

  typedef struct packed {
    logic       item_kind;
    logic [7:0] pdu_byte;
    logic [7:0] station_address;
    logic [7:0] pdu_length;
    logic [1:0] frame_status;
    logic       last;
  } out_t;

  typedef struct packed {
    logic       has_pdu;
    logic [7:0] pdu_byte;
    logic       has_verdict;
    logic [7:0] station_address;
    logic [7:0] pdu_length;
    logic [1:0] frame_status;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < BITS_PER_BYTE; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ===== rtl/mrfc_front.sv =====
// Front part: accepts frame bytes, runs the delay line, CRC and byte count,
// and classifies the bytes into queue commands. Depends on mrfc_pkg.
`timescale 1ns / 1ps

module mrfc_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  mrfc_pkg::in_t in_data,
  input  mrfc_pkg::qstat_t q_stat,
  output logic          push,
  output mrfc_pkg::cmd_t push_cmd
);
  import mrfc_pkg::*;

  logic [15:0]      crc_r, crc_nxt;
  logic [7:0]       held0_r, held0_nxt;
  logic [7:0]       held1_r, held1_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [7:0]       addr_r, addr_nxt;

  logic             accept;
  logic             feed;
  logic             pdu_out;
  logic [15:0]      crc_fed;
  logic [7:0]       addr_cur;
  logic [CNT_W-1:0] count_inc;
  logic [15:0]      rx_crc;
  logic             eof;

  assign in_ready = !q_stat.full;
  assign accept   = in_valid && in_ready;
  assign eof      = in_data.end_of_frame;

  assign feed      = count_r >= CNT_W'(CRC_BYTES);
  assign pdu_out   = count_r > CNT_W'(CRC_BYTES);
  assign crc_fed   = feed ? crc_feed(crc_r, held0_r) : crc_r;
  assign addr_cur  = (count_r == CNT_W'(CRC_BYTES)) ? held0_r : addr_r;
  assign count_inc = (count_r < CNT_W'(MAX_FRAME_BYTES + 1)) ? count_r + CNT_W'(1) : count_r;
  assign rx_crc    = {in_data.rx_byte, held1_r};

  always_comb begin
    push_cmd             = '0;
    push_cmd.has_pdu     = pdu_out;
    push_cmd.pdu_byte    = held0_r;
    push_cmd.has_verdict = eof;
    if (count_inc < CNT_W'(MIN_FRAME)) begin
      push_cmd.frame_status = STATUS_SHORT;
    end else begin
      push_cmd.station_address = addr_cur;
      if (count_inc > CNT_W'(MAX_FRAME_BYTES)) begin
        push_cmd.frame_status = STATUS_OVERLONG;
      end else if (rx_crc != crc_fed) begin
        push_cmd.frame_status = STATUS_CRC_ERR;
      end else begin
        push_cmd.frame_status = STATUS_OK;
        push_cmd.pdu_length   = 8'(count_inc - CNT_W'(MIN_FRAME));
      end
    end
  end

  assign push = accept && (pdu_out || eof);

  always_comb begin
    crc_nxt   = crc_r;
    held0_nxt = held0_r;
    held1_nxt = held1_r;
    count_nxt = count_r;
    addr_nxt  = addr_r;
    if (accept) begin
      if (eof) begin
        crc_nxt   = CRC_INIT;
        held0_nxt = '0;
        held1_nxt = '0;
        count_nxt = '0;
        addr_nxt  = '0;
      end else begin
        crc_nxt   = crc_fed;
        held0_nxt = held1_r;
        held1_nxt = in_data.rx_byte;
        count_nxt = count_inc;
        addr_nxt  = addr_cur;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r   <= CRC_INIT;
      held0_r <= '0;
      held1_r <= '0;
      count_r <= '0;
      addr_r  <= '0;
    end else begin
      crc_r   <= crc_nxt;
      held0_r <= held0_nxt;
      held1_r <= held1_nxt;
      count_r <= count_nxt;
      addr_r  <= addr_nxt;
    end
  end

endmodule

// ===== rtl/mrfc_queue.sv =====
// Command queue between front and back parts: small register FIFO.
// Depends on mrfc_pkg.
`timescale 1ns / 1ps

module mrfc_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  mrfc_pkg::cmd_t   push_cmd,
  input  logic             pop,
  output mrfc_pkg::cmd_t   head,
  output mrfc_pkg::qstat_t q_stat
);
  import mrfc_pkg::*;

  cmd_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr_r, wptr_nxt;
  logic [QPTR_W-1:0] rptr_r, rptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  assign q_stat.full  = cnt_r == QCNT_W'(QUEUE_DEPTH);
  assign q_stat.empty = cnt_r == '0;
  assign head         = mem_r[rptr_r];

  always_comb begin
    wptr_nxt = push ? wptr_r + QPTR_W'(1) : wptr_r;
    rptr_nxt = pop ? rptr_r + QPTR_W'(1) : rptr_r;
    cnt_nxt  = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + QCNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= push_cmd;
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && q_stat.full)) else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && q_stat.empty)) else $error("queue pop while empty");
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QCNT_W'(QUEUE_DEPTH)) else $error("queue count out of range");
`endif

endmodule

// ===== rtl/mrfc_back.sv =====
// Back part: expands queue commands into result words and holds them in
// the output register. Depends on mrfc_pkg.
`timescale 1ns / 1ps

module mrfc_back (
  input  logic             clk,
  input  logic             rst_n,
  input  mrfc_pkg::cmd_t   head,
  input  mrfc_pkg::qstat_t q_stat,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output mrfc_pkg::out_t   out_data
);
  import mrfc_pkg::*;

  logic out_valid_r, out_valid_nxt;
  out_t out_r, out_nxt;
  logic pdu_done_r, pdu_done_nxt;
  logic load;

  assign load = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    pdu_done_nxt  = pdu_done_r;
    pop           = 1'b0;
    if (load) begin
      out_valid_nxt = !q_stat.empty;
      if (!q_stat.empty) begin
        out_nxt = '0;
        if (head.has_pdu && !pdu_done_r) begin
          out_nxt.item_kind = KIND_PDU;
          out_nxt.pdu_byte  = head.pdu_byte;
          out_nxt.last      = !head.has_verdict;
          if (head.has_verdict) begin
            pdu_done_nxt = 1'b1;
          end else begin
            pop = 1'b1;
          end
        end else begin
          out_nxt.item_kind       = KIND_VERDICT;
          out_nxt.station_address = head.station_address;
          out_nxt.pdu_length      = head.pdu_length;
          out_nxt.frame_status    = head.frame_status;
          out_nxt.last            = 1'b1;
          pdu_done_nxt            = 1'b0;
          pop                     = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pdu_done_r  <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      pdu_done_r  <= pdu_done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTH
  a_split_pending: assert property (@(posedge clk) disable iff (!rst_n)
    pdu_done_r |-> (!q_stat.empty && head.has_verdict))
    else $error("split command lost its verdict");
`endif

endmodule

// ===== rtl/modbus_rtu_frame_checker.sv =====
// Modbus RTU frame checker: top level joining front, queue and back parts.
// Depends on mrfc_pkg, mrfc_front, mrfc_queue, mrfc_back.
//
// Usage: received frame bytes enter on the in_ channel, one word per byte,
// with end_of_frame set on the final byte. Results leave on the out_
// channel: a PDU byte word for every byte between address and CRC, and a
// verdict word (address, PDU length, status) after the final byte.
// Throughput: one input byte per cycle unless the queue is full; a final
// byte that also releases a PDU byte yields two result words in turn,
// limited by the single output register. A result passes through the
// queue and then the output register. The front part updates the CRC by
// one byte per cycle while bytes are accepted, with an eight-step shift
// network. A four-entry command queue lets the front keep accepting while
// the receiver stalls; in_ready drops only when the queue is full.
// Reset (synchronous, rst_n low) empties queue and output register and
// returns the CRC, delay line, count and address to their start values.
`timescale 1ns / 1ps

module modbus_rtu_frame_checker (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  mrfc_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output mrfc_pkg::out_t out_data
);
  import mrfc_pkg::*;

  logic   push;
  logic   pop;
  cmd_t   push_cmd;
  cmd_t   head;
  qstat_t q_stat;

  mrfc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_stat   (q_stat),
    .push     (push),
    .push_cmd (push_cmd)
  );

  mrfc_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .q_stat   (q_stat)
  );

  mrfc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .q_stat    (q_stat),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== sim/modbus_rtu_frame_checker_tb.sv =====
// Testbench for modbus_rtu_frame_checker: drives whole RTU frames and checks every word out.
// A frame-level model predicts PDU and verdict words; valid/ready idle at random on both sides.
// Depends on mrfc_pkg and the modbus_rtu_frame_checker RTL.
`timescale 1ns / 1ps

module modbus_rtu_frame_checker_tb;
  import mrfc_pkg::*;

  localparam int IDLE_LIMIT  = 2000;
  localparam int WORD_TARGET = 1100;
  localparam int TAIL_START  = 950;
  localparam int HOLD_OFF    = 60;

  class frame_verdict_board;
    logic [15:0] crc;
    logic [7:0]  held [2];
    int          count;
    logic [7:0]  address;
    out_t        expected_words [$];
    int          errors;

    function new();
      errors = 0;
      clear();
    endfunction

    function void clear();
      crc     = CRC_INIT;
      held[0] = 8'h00;
      held[1] = 8'h00;
      count   = 0;
      address = 8'h00;
    endfunction

    static function logic [15:0] crc_after_byte(logic [15:0] c, logic [7:0] b);
      logic [15:0] r;
      r = c ^ {8'h00, b};
      repeat (BITS_PER_BYTE) begin
        r = r[0] ? ({1'b0, r[15:1]} ^ CRC_POLY) : {1'b0, r[15:1]};
      end
      return r;
    endfunction

    function void take_byte(in_t w);
      out_t o;
      logic pdu_out;
      logic [7:0] leaving;
      pdu_out = 1'b0;
      leaving = held[0];
      if (count >= CRC_BYTES) begin
        crc = crc_after_byte(crc, leaving);
        if (count == CRC_BYTES) begin
          address = leaving;
        end else begin
          pdu_out = 1'b1;
        end
      end
      held[0] = held[1];
      held[1] = w.rx_byte;
      if (count < MAX_FRAME_BYTES + 1) begin
        count++;
      end
      if (pdu_out) begin
        o = '0;
        o.item_kind = KIND_PDU;
        o.pdu_byte = leaving;
        o.frame_status = STATUS_OK;
        o.last = !w.end_of_frame;
        expected_words.push_back(o);
      end
      if (w.end_of_frame) begin
        o = '0;
        o.item_kind = KIND_VERDICT;
        o.last = 1'b1;
        if (count < MIN_FRAME) begin
          o.frame_status = STATUS_SHORT;
        end else begin
          o.station_address = address;
          if (count > MAX_FRAME_BYTES) begin
            o.frame_status = STATUS_OVERLONG;
          end else if ({held[1], held[0]} != crc) begin
            o.frame_status = STATUS_CRC_ERR;
          end else begin
            o.frame_status = STATUS_OK;
            o.pdu_length = 8'(count - MIN_FRAME);
          end
        end
        expected_words.push_back(o);
        clear();
      end
    endfunction

    function void compare(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_word(out_t got);
      out_t want;
      if (expected_words.size() == 0) begin
        $error("unexpected word %0h", got);
        errors++;
        return;
      end
      want = expected_words.pop_front();
      compare("item_kind", 16'(want.item_kind), 16'(got.item_kind));
      compare("pdu_byte", 16'(want.pdu_byte), 16'(got.pdu_byte));
      compare("station_address", 16'(want.station_address), 16'(got.station_address));
      compare("pdu_length", 16'(want.pdu_length), 16'(got.pdu_length));
      compare("frame_status", 16'(want.frame_status), 16'(got.frame_status));
      compare("last", 16'(want.last), 16'(got.last));
    endfunction

    function int pending();
      return expected_words.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_t  in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;

  frame_verdict_board board;
  logic [7:0] frame_q [$];
  int words_sent;
  int words_in;
  int idle_cycles;
  bit tail;

  modbus_rtu_frame_checker dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        board.take_byte(in_data);
        words_in++;
      end
      if (out_valid && out_ready) begin
        board.check_word(out_data);
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    bit held_off;
    held_off = 1'b0;
    out_ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!held_off && words_in >= 150) begin
        // hold off long enough for the queue to fill and stall the input
        held_off = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_OFF) @(posedge clk);
      end else if (tail || $urandom_range(0, 2) != 0) begin
        out_ready <= 1'b1;
        repeat (tail ? 1 : $urandom_range(1, 16)) @(posedge clk);
      end else begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end
    end
  end

  task automatic send_word(logic [7:0] b, logic eof, bit idle_on);
    in_t w;
    int gap;
    w.rx_byte = b;
    w.end_of_frame = eof;
    gap = (idle_on && !tail && $urandom_range(0, 3) == 0) ? $urandom_range(1, 13) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
  endtask

  task automatic send_frame();
    bit idle_on;
    idle_on = $urandom_range(0, 2) != 0;
    foreach (frame_q[i]) begin
      send_word(frame_q[i], i == frame_q.size() - 1, idle_on);
    end
  endtask

  task automatic add_crc(bit corrupt);
    logic [15:0] c;
    int pos;
    c = CRC_INIT;
    foreach (frame_q[i]) begin
      c = frame_verdict_board::crc_after_byte(c, frame_q[i]);
    end
    frame_q.push_back(c[7:0]);
    frame_q.push_back(c[15:8]);
    if (corrupt) begin
      pos = $urandom_range(0, frame_q.size() - 1);
      frame_q[pos] = frame_q[pos] ^ (8'h01 << $urandom_range(0, 7));
    end
  endtask

  task automatic fill_random(int n);
    frame_q.delete();
    repeat (n) frame_q.push_back(8'($urandom_range(0, 255)));
  endtask

  initial begin
    bit did_max;
    bit did_over;
    int pick;
    board = new();
    words_sent = 0;
    words_in = 0;
    idle_cycles = 0;
    tail = 1'b0;
    did_max = 1'b0;
    did_over = 1'b0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    frame_q = '{8'hFF};
    send_frame();
    frame_q = '{8'h00, 8'hA5};
    send_frame();
    frame_q = '{8'hFF};
    add_crc(1'b0);
    send_frame();
    frame_q = '{8'h00, 8'hFF};
    add_crc(1'b0);
    send_frame();
    frame_q = '{8'h80, 8'h00};
    add_crc(1'b1);
    send_frame();
    frame_q = '{8'h01};
    add_crc(1'b1);
    send_frame();
    frame_q = '{8'h5A, 8'h00, 8'hFF};
    add_crc(1'b0);
    send_frame();

    while (words_sent < WORD_TARGET) begin
      if (words_sent >= TAIL_START) begin
        tail = 1'b1;
      end
      if (!did_max && words_sent >= 300) begin
        // longest frame that still passes
        did_max = 1'b1;
        fill_random(MAX_FRAME_BYTES - CRC_BYTES);
        add_crc(1'b0);
      end else if (!did_over && words_sent >= 500) begin
        // one byte too long, CRC still good
        did_over = 1'b1;
        fill_random(MAX_FRAME_BYTES - CRC_BYTES + 1);
        add_crc(1'b0);
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 15) begin
          fill_random($urandom_range(1, 2));
        end else begin
          fill_random($urandom_range(1, 9));
          add_crc(pick < 30);
        end
      end
      send_frame();
    end
    in_valid <= 1'b0;

    while (board.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (board.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
